// ===== sv/tpts_pkg.sv =====
`default_nettype none

package tpts_pkg;

  localparam int CordicSteps = 24;
  localparam int CordicLat   = CordicSteps + 1;
  localparam int CordicW     = 58;
  localparam int AngleZW     = 26;

  typedef enum logic {
    CFG_ORIGIN_Z       = 1'b0,
    CFG_FIELD_STRENGTH = 1'b1
  } cfg_idx_e;

  // Arctangent of 2^-i with pi = 2^24.
  localparam logic [22:0] AtanTab [CordicSteps] = '{
    23'd4194304, 23'd2476042, 23'd1308273, 23'd664100, 23'd333339, 23'd166832,
    23'd83436, 23'd41721, 23'd20861, 23'd10430, 23'd5215, 23'd2608,
    23'd1304, 23'd652, 23'd326, 23'd163, 23'd81, 23'd41,
    23'd20, 23'd10, 23'd5, 23'd3, 23'd1, 23'd1
  };

endpackage

`default_nettype wire

// ===== sv/three_point_track_seed_params.sv =====
`default_nettype none

// Throughput: one word per cycle; busy_o stays low and a result is shown for one cycle.
// The latency is set by the square root (32 stages) feeding the polar CORDIC (25 stages).
// Reset clears the valid pipeline and loads the configuration registers with their
// reset values; words in flight are dropped.
module three_point_track_seed_params (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic signed [23:0] first_x_i,
  input  logic signed [23:0] first_y_i,
  input  logic signed [23:0] first_z_i,
  input  logic signed [23:0] second_x_i,
  input  logic signed [23:0] second_y_i,
  input  logic signed [23:0] second_z_i,
  input  logic signed [23:0] third_x_i,
  input  logic signed [23:0] third_y_i,
  input  logic signed [23:0] third_z_i,
  output logic               done_o,
  output logic signed [23:0] loc_x_o,
  output logic signed [23:0] loc_y_o,
  output logic signed [15:0] azimuth_o,
  output logic [15:0]        polar_angle_o,
  output logic signed [31:0] charge_over_momentum_o,
  output logic               degenerate_o
);

  typedef struct packed {
    logic        valid;
    logic        deg;
    logic        dxneg;
    logic        dyneg;
    logic        dzneg;
    logic        lzneg;
    logic        lnegx;
    logic        lnegy;
    logic        qpos;
    logic        nzero;
    logic        fzero;
    logic [23:0] adz;
    logic [23:0] x1;
    logic [23:0] y1;
    logic [23:0] locx;
    logic [23:0] locy;
    logic [15:0] phi;
    logic [31:0] qop;
  } side_t;

  localparam logic [17:0] FieldReset = 18'd37356;
  localparam logic [23:0] QopScale   = 24'd10000000;
  localparam int SqrtSteps = 32;
  localparam int LocSteps  = 26;
  localparam int QopSteps  = 32;
  localparam int StAzIn    = 2;
  localparam int StSqIn    = 3;
  localparam int StLocDiv  = 4;
  localparam int StQDiv    = 9;
  localparam int StPhi     = StAzIn + tpts_pkg::CordicLat + 1;
  localparam int StLoc     = StLocDiv + LocSteps + 1;
  localparam int StQop     = StQDiv + QopSteps + 1;
  localparam int StPolIn   = StSqIn + SqrtSteps;
  localparam int StLast    = StPolIn + tpts_pkg::CordicLat;
  localparam int Latency   = StLast + 1;

  logic signed [23:0] origin_z_q;
  logic [17:0]        field_q;
  logic               accept;

  logic signed [24:0] dx_c, dy_c, dz_c, ly_c, lz_c, h_c;
  side_t              side_c;
  side_t              side_q [1:StLast];
  side_t              side_d [1:StLast];

  logic signed [24:0] dx1_q, dy1_q, dz1_q, ly1_q, lz1_q, h1_q;
  logic signed [49:0] hdx2_q, hdy2_q, dylz2_q, dzly2_q;
  logic signed [49:0] lysq2_q, lzsq2_q, uxsq2_q, uysq2_q;
  logic [23:0]        ux2_q, uy2_q;
  logic [43:0]        a2_q, a3_q, a4_q;
  logic [19:0]        f3_c;
  logic [23:0]        alz_c;
  logic [48:0]        ahdx_c, ahdy_c;

  logic [51:0]        lnum3_q [2];
  logic [24:0]        lden3_q;
  logic signed [50:0] n3_q;
  logic [49:0]        l2_3_q, l2_4_q;
  logic [49:0]        an4_q;
  logic [48:0]        pnlo5_q, pnhi5_q;
  logic [46:0]        pp00_5_q, pp01_5_q, pp10_5_q, pp11_5_q;
  logic [74:0]        nm6_q, nm7_q;
  logic [72:0]        sa6_q, sb6_q;
  logic [95:0]        den7_q;
  logic [127:0]       qnum8_q;
  logic [96:0]        qden8_q;

  logic [127:0]       qrem_q [0:QopSteps];
  logic [31:0]        qq_q   [0:QopSteps];
  logic               qbig_q [0:QopSteps];
  logic [96:0]        qd_q   [0:QopSteps];

  logic [51:0]        lrem_q [2][0:LocSteps];
  logic [25:0]        lq_q   [2][0:LocSteps];
  logic               lbig_q [2][0:LocSteps];
  logic [24:0]        ld_q   [0:LocSteps];

  logic [63:0]        sqn_q [0:SqrtSteps];
  logic [63:0]        sqr_q [0:SqrtSteps];

  logic [15:0]        az_ang, pol_ang, phi_c, theta_c;
  logic [23:0]        locx_c, locy_c;
  logic [32:0]        mlim_c, qmag_c;
  logic [31:0]        qop_c;

  logic               done_q, deg_q;
  logic [23:0]        locx_q, locy_q;
  logic [15:0]        phi_q, theta_q;
  logic [31:0]        qop_q;

  function automatic logic [23:0] loc_fin(input logic big, input logic neg,
                                          input logic [25:0] q, input logic [23:0] p);
    logic signed [27:0] t;
    logic [23:0]        r;
    t = $signed({{4{p[23]}}, p}) + (neg ? $signed({2'b0, q}) : -$signed({2'b0, q}));
    if (big) begin
      r = neg ? 24'h7FFFFF : 24'h800000;
    end else if (t > 28'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (t < -28'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = t[23:0];
    end
    return r;
  endfunction

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_z_q <= '0;
      field_q    <= FieldReset;
    end else if (cfg_we_i) begin
      case (tpts_pkg::cfg_idx_e'(cfg_index_i))
        tpts_pkg::CFG_ORIGIN_Z:       origin_z_q <= cfg_data_i;
        tpts_pkg::CFG_FIELD_STRENGTH: field_q    <= cfg_data_i[17:0];
        default:                      ;
      endcase
    end
  end

  assign dx_c = $signed({second_x_i[23], second_x_i}) - $signed({first_x_i[23], first_x_i});
  assign dy_c = $signed({second_y_i[23], second_y_i}) - $signed({first_y_i[23], first_y_i});
  assign dz_c = $signed({second_z_i[23], second_z_i}) - $signed({first_z_i[23], first_z_i});
  assign ly_c = $signed({third_y_i[23], third_y_i}) - $signed({first_y_i[23], first_y_i});
  assign lz_c = $signed({third_z_i[23], third_z_i}) - $signed({first_z_i[23], first_z_i});
  assign h_c  = $signed({first_z_i[23], first_z_i}) - $signed({origin_z_q[23], origin_z_q});

  always_comb begin
    side_c       = '0;
    side_c.valid = accept;
    side_c.deg   = (dz_c == '0) || (lz_c == '0);
    side_c.dxneg = dx_c[24];
    side_c.dyneg = dy_c[24];
    side_c.dzneg = dz_c[24];
    side_c.lzneg = lz_c[24];
    side_c.fzero = (field_q == '0);
    side_c.adz   = dz_c[24] ? 24'(-dz_c) : dz_c[23:0];
    side_c.x1    = first_x_i;
    side_c.y1    = first_y_i;
  end

  // Side-band word: flags and finished results ride along to the output stage.
  always_comb begin
    side_d[1] = side_c;
    for (int k = 2; k <= StLast; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[StSqIn].lnegx   = hdx2_q[49] ^ side_q[StSqIn-1].dzneg;
    side_d[StSqIn].lnegy   = hdy2_q[49] ^ side_q[StSqIn-1].dzneg;
    side_d[StSqIn+1].qpos  = n3_q[50] != side_q[StSqIn].lzneg;
    side_d[StSqIn+1].nzero = (n3_q == '0);
    side_d[StPhi].phi      = phi_c;
    side_d[StLoc].locx     = locx_c;
    side_d[StLoc].locy     = locy_c;
    side_d[StQop].qop      = qop_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= StLast; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      for (int k = 1; k <= StLast; k++) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  assign f3_c   = {2'b0, field_q} + {1'b0, field_q, 1'b0};
  assign alz_c  = lz1_q[24] ? 24'(-lz1_q) : lz1_q[23:0];
  assign ahdx_c = hdx2_q[49] ? 49'(-hdx2_q) : hdx2_q[48:0];
  assign ahdy_c = hdy2_q[49] ? 49'(-hdy2_q) : hdy2_q[48:0];

  always_ff @(posedge clk_i) begin
    dx1_q <= dx_c;
    dy1_q <= dy_c;
    dz1_q <= dz_c;
    ly1_q <= ly_c;
    lz1_q <= lz_c;
    h1_q  <= h_c;

    hdx2_q  <= h1_q * dx1_q;
    hdy2_q  <= h1_q * dy1_q;
    dylz2_q <= dy1_q * lz1_q;
    dzly2_q <= dz1_q * ly1_q;
    lysq2_q <= ly1_q * ly1_q;
    lzsq2_q <= lz1_q * lz1_q;
    uxsq2_q <= dx1_q * dx1_q;
    uysq2_q <= dy1_q * dy1_q;
    ux2_q   <= dx1_q[24] ? 24'(-dx1_q) : dx1_q[23:0];
    uy2_q   <= dy1_q[24] ? 24'(-dy1_q) : dy1_q[23:0];
    a2_q    <= f3_c * alz_c;

    lnum3_q[0] <= 52'({ahdx_c, 1'b0}) + 52'(side_q[StSqIn-1].adz);
    lnum3_q[1] <= 52'({ahdy_c, 1'b0}) + 52'(side_q[StSqIn-1].adz);
    lden3_q    <= {side_q[StSqIn-1].adz, 1'b0};
    n3_q       <= 51'(dylz2_q) - 51'(dzly2_q);
    l2_3_q     <= 50'(lysq2_q[47:0]) + 50'(lzsq2_q[47:0]);
    a3_q       <= a2_q;

    an4_q  <= n3_q[50] ? 50'(-n3_q) : n3_q[49:0];
    l2_4_q <= l2_3_q;
    a4_q   <= a3_q;

    pnlo5_q  <= an4_q[24:0] * QopScale;
    pnhi5_q  <= an4_q[49:25] * QopScale;
    pp00_5_q <= a4_q[21:0] * l2_4_q[24:0];
    pp01_5_q <= a4_q[21:0] * l2_4_q[49:25];
    pp10_5_q <= a4_q[43:22] * l2_4_q[24:0];
    pp11_5_q <= a4_q[43:22] * l2_4_q[49:25];

    nm6_q <= 75'(pnlo5_q) + 75'({pnhi5_q, 25'b0});
    sa6_q <= 73'(pp00_5_q) + 73'({pp01_5_q, 25'b0});
    sb6_q <= 73'(pp10_5_q) + 73'({pp11_5_q, 25'b0});

    nm7_q  <= nm6_q;
    den7_q <= 96'(sa6_q) + 96'({sb6_q, 22'b0});

    qnum8_q <= {17'b0, nm7_q, 36'b0} + 128'(den7_q);
    qden8_q <= {den7_q, 1'b0};
  end

  // Momentum divider: overflow check, then one quotient bit per stage.
  always_ff @(posedge clk_i) begin
    qbig_q[0] <= {1'b0, qnum8_q} >= {qden8_q, 32'b0};
    qrem_q[0] <= qnum8_q;
    qq_q[0]   <= '0;
    qd_q[0]   <= qden8_q;
    for (int k = 1; k <= QopSteps; k++) begin
      if (qrem_q[k-1] >= (128'(qd_q[k-1]) << (QopSteps - k))) begin
        qrem_q[k] <= qrem_q[k-1] - (128'(qd_q[k-1]) << (QopSteps - k));
        qq_q[k]   <= qq_q[k-1] | (32'd1 << (QopSteps - k));
      end else begin
        qrem_q[k] <= qrem_q[k-1];
        qq_q[k]   <= qq_q[k-1];
      end
      qbig_q[k] <= qbig_q[k-1];
      qd_q[k]   <= qd_q[k-1];
    end
  end

  // Location dividers for the x and y lanes share the divisor.
  always_ff @(posedge clk_i) begin
    ld_q[0] <= lden3_q;
    for (int k = 1; k <= LocSteps; k++) begin
      ld_q[k] <= ld_q[k-1];
    end
    for (int l = 0; l < 2; l++) begin
      lbig_q[l][0] <= {1'b0, lnum3_q[l]} >= {2'b0, lden3_q, 26'b0};
      lrem_q[l][0] <= lnum3_q[l];
      lq_q[l][0]   <= '0;
      for (int k = 1; k <= LocSteps; k++) begin
        if (lrem_q[l][k-1] >= (52'(ld_q[k-1]) << (LocSteps - k))) begin
          lrem_q[l][k] <= lrem_q[l][k-1] - (52'(ld_q[k-1]) << (LocSteps - k));
          lq_q[l][k]   <= lq_q[l][k-1] | (26'd1 << (LocSteps - k));
        end else begin
          lrem_q[l][k] <= lrem_q[l][k-1];
          lq_q[l][k]   <= lq_q[l][k-1];
        end
        lbig_q[l][k] <= lbig_q[l][k-1];
      end
    end
  end

  // Integer square root, one result bit per stage.
  always_ff @(posedge clk_i) begin
    sqn_q[0] <= {1'b0, 49'(uxsq2_q[47:0]) + 49'(uysq2_q[47:0]), 14'b0};
    sqr_q[0] <= '0;
    for (int k = 1; k <= SqrtSteps; k++) begin
      if (sqn_q[k-1] >= sqr_q[k-1] + (64'd1 << (64 - 2 * k))) begin
        sqn_q[k] <= sqn_q[k-1] - sqr_q[k-1] - (64'd1 << (64 - 2 * k));
        sqr_q[k] <= (sqr_q[k-1] >> 1) + (64'd1 << (64 - 2 * k));
      end else begin
        sqn_q[k] <= sqn_q[k-1];
        sqr_q[k] <= sqr_q[k-1] >> 1;
      end
    end
  end

  tpts_cordic u_az_cordic (
    .clk_i   (clk_i),
    .a_i     ({8'b0, ux2_q}),
    .b_i     ({8'b0, uy2_q}),
    .angle_o (az_ang)
  );

  tpts_cordic u_pol_cordic (
    .clk_i   (clk_i),
    .a_i     ({1'b0, side_q[StPolIn].adz, 7'b0}),
    .b_i     (sqr_q[SqrtSteps][31:0]),
    .angle_o (pol_ang)
  );

  always_comb begin
    if (!side_q[StPhi-1].dxneg) begin
      phi_c = side_q[StPhi-1].dyneg ? 16'(-az_ang) : az_ang;
    end else begin
      phi_c = side_q[StPhi-1].dyneg ? az_ang - 16'h8000 : 16'h8000 - az_ang;
    end
  end

  assign locx_c = loc_fin(lbig_q[0][LocSteps], side_q[StLoc-1].lnegx, lq_q[0][LocSteps],
                          side_q[StLoc-1].x1);
  assign locy_c = loc_fin(lbig_q[1][LocSteps], side_q[StLoc-1].lnegy, lq_q[1][LocSteps],
                          side_q[StLoc-1].y1);

  always_comb begin
    mlim_c = side_q[StQop-1].qpos ? 33'h07FFFFFFF : 33'h080000000;
    if (qbig_q[QopSteps] || side_q[StQop-1].fzero || ({1'b0, qq_q[QopSteps]} > mlim_c)) begin
      qmag_c = mlim_c;
    end else begin
      qmag_c = {1'b0, qq_q[QopSteps]};
    end
    if (side_q[StQop-1].nzero) begin
      qop_c = '0;
    end else begin
      qop_c = side_q[StQop-1].qpos ? qmag_c[31:0] : 32'(-qmag_c);
    end
  end

  assign theta_c = side_q[StLast].dzneg ? 16'h8000 - pol_ang : pol_ang;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_q[StLast].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= side_q[StLast].deg;
    if (side_q[StLast].deg) begin
      locx_q  <= '0;
      locy_q  <= '0;
      phi_q   <= '0;
      theta_q <= '0;
      qop_q   <= '0;
    end else begin
      locx_q  <= side_q[StLast].locx;
      locy_q  <= side_q[StLast].locy;
      phi_q   <= side_q[StLast].phi;
      theta_q <= theta_c;
      qop_q   <= side_q[StLast].qop;
    end
  end

  assign done_o                 = done_q;
  assign degenerate_o           = deg_q;
  assign loc_x_o                = locx_q;
  assign loc_y_o                = locy_q;
  assign azimuth_o              = phi_q;
  assign polar_angle_o          = theta_q;
  assign charge_over_momentum_o = qop_q;

`ifndef SYNTHESIS
  a_word_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("accepted word did not return after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result strobe without an accepted word");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (loc_x_o == '0 && loc_y_o == '0 && azimuth_o == '0 &&
                                  polar_angle_o == '0 && charge_over_momentum_o == '0))
    else $error("degenerate word carries nonzero fields");

  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (polar_angle_o <= 16'd32768))
    else $error("polar angle beyond pi");
`endif

endmodule

`default_nettype wire

// ===== sv/tpts_cordic.sv =====
`default_nettype none

module tpts_cordic (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [15:0] angle_o
);

  localparam int N  = tpts_pkg::CordicSteps;
  localparam int W  = tpts_pkg::CordicW;
  localparam int ZW = tpts_pkg::AngleZW;

  logic signed [W-1:0]  x_q [N];
  logic signed [W-1:0]  y_q [N];
  logic signed [ZW-1:0] z_q [N];
  logic                 zero_q [N];
  logic signed [W-1:0]  x0;
  logic signed [W-1:0]  y0;
  logic [15:0]          angle_d;
  logic [15:0]          angle_q;

  assign x0 = $signed({4'b0, a_i, 22'b0});
  assign y0 = $signed({4'b0, b_i, 22'b0});

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x0 + y0;
    y_q[0]    <= y0 - x0;
    z_q[0]    <= ZW'(tpts_pkg::AtanTab[0]);
    zero_q[0] <= (a_i == '0) && (b_i == '0);
    for (int k = 1; k < N; k++) begin
      if (!y_q[k-1][W-1]) begin
        x_q[k] <= x_q[k-1] + (y_q[k-1] >>> k);
        y_q[k] <= y_q[k-1] - (x_q[k-1] >>> k);
        z_q[k] <= z_q[k-1] + ZW'(tpts_pkg::AtanTab[k]);
      end else begin
        x_q[k] <= x_q[k-1] - (y_q[k-1] >>> k);
        y_q[k] <= y_q[k-1] + (x_q[k-1] >>> k);
        z_q[k] <= z_q[k-1] - ZW'(tpts_pkg::AtanTab[k]);
      end
      zero_q[k] <= zero_q[k-1];
    end
  end

  always_comb begin
    logic [23:0] zc;
    logic [24:0] zr;
    if (z_q[N-1][ZW-1]) begin
      zc = '0;
    end else if (z_q[N-1] > 26'sd8388608) begin
      zc = 24'd8388608;
    end else begin
      zc = z_q[N-1][23:0];
    end
    zr = {1'b0, zc} + 25'd256;
    angle_d = zero_q[N-1] ? 16'd0 : 16'(zr >> 9);
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign angle_o = angle_q;

endmodule

`default_nettype wire

// ===== sim/tb_three_point_track_seed_params.sv =====
module tb_three_point_track_seed_params;

  typedef struct {
    logic signed [23:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
  } points_t;

  typedef struct {
    logic signed [23:0] loc_x, loc_y;
    logic signed [15:0] azimuth;
    logic [15:0]        polar;
    logic signed [31:0] qop;
    logic               degen;
  } seed_t;

  localparam int LatencyCycles = 61;
  localparam int WatchdogLimit = 4000;

  localparam longint AtanTbl [24] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  logic clk_i, rst_ni, busy_o, cfg_we_i, cfg_index_i, done_o, degenerate_o;
  logic start_i = 1'b0;
  logic [23:0] cfg_data_i;
  logic signed [23:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic signed [23:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic signed [23:0] third_x_i = '0, third_y_i = '0, third_z_i = '0;
  logic signed [23:0] loc_x_o, loc_y_o;
  logic signed [15:0] azimuth_o;
  logic [15:0] polar_angle_o;
  logic signed [31:0] charge_over_momentum_o;

  points_t pending_words[$];
  seed_t   expected_seeds[$];
  logic signed [23:0] plane_z;
  logic [17:0] field_b;
  int gap_left, idle_cycles;
  int errors = 0;
  bit burst_mode;

  three_point_track_seed_params u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cordic_atan(longint unsigned a, longint unsigned b);
    longint x, y, z, sx, sy;
    x = longint'(a << 22);
    y = longint'(b << 22);
    z = 0;
    if (a == 0 && b == 0) return 0;
    for (int i = 0; i < 24; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (y >= 0) begin
        x = x + sy; y = y - sx; z += AtanTbl[i];
      end else begin
        x = x - sy; y = y + sx; z -= AtanTbl[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 8388608) z = 8388608;
    return (z + 256) >> 9;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint unsigned un, ud, q;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat24(longint v);
    return v < -8388608 ? -8388608 : (v > 8388607 ? 8388607 : v);
  endfunction

  function automatic seed_t estimate_seed(points_t p);
    seed_t s;
    longint dx, dy, dz, ly, lz, h, b, phi, theta, n, qop;
    longint unsigned ux, uy, mlim, l2;
    logic [127:0] den, num, qf;
    bit pos;
    s = '{default: '0};
    dz = longint'(p.z2) - p.z1;
    lz = longint'(p.z3) - p.z1;
    if (dz == 0 || lz == 0) begin
      s.degen = 1'b1;
      return s;
    end
    dx = longint'(p.x2) - p.x1;
    dy = longint'(p.y2) - p.y1;
    h = longint'(p.z1) - plane_z;
    s.loc_x = 24'(sat24(p.x1 - round_div(h * dx, dz)));
    s.loc_y = 24'(sat24(p.y1 - round_div(h * dy, dz)));
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    b = cordic_atan(ux, uy);
    if (dx >= 0) phi = dy >= 0 ? b : -b;
    else phi = dy >= 0 ? 32768 - b : b - 32768;
    s.azimuth = 16'(phi);
    b = cordic_atan((dz < 0 ? -dz : dz) * 128, isqrt64((ux * ux + uy * uy) << 14));
    theta = dz > 0 ? b : 32768 - b;
    s.polar = 16'(theta);
    ly = longint'(p.y3) - p.y1;
    n = dy * lz - dz * ly;
    qop = 0;
    if (n != 0) begin
      pos = (n < 0) != (lz < 0);
      mlim = pos ? 64'd2147483647 : 64'd2147483648;
      if (field_b != 0) begin
        l2 = ly * ly + lz * lz;
        den = 128'(3 * longint'(field_b) * (lz < 0 ? -lz : lz)) * 128'(l2);
        num = ((128'(n < 0 ? -n : n) * 128'd10000000) << 36) + den;
        qf = num / (den << 1);
        if (qf > 128'(mlim)) qf = 128'(mlim);
      end else begin
        qf = 128'(mlim);
      end
      qop = pos ? longint'(qf) : -longint'(qf);
    end
    s.qop = 32'(qop);
    return s;
  endfunction

  function automatic points_t random_points();
    points_t p;
    p = '{24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
          24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
          24'($urandom())};
    return p;
  endfunction

  function automatic points_t track_points();
    points_t p;
    int z1, s1, s2, x1, y1, sx, sy, sag;
    z1 = $urandom_range(0, 6000000) - 3000000;
    s1 = $urandom_range(1, 1000000);
    s2 = s1 + $urandom_range(1, 1000000);
    if ($urandom_range(0, 3) == 0) begin
      s1 = -s1;
      s2 = -s2;
    end
    x1 = $urandom_range(0, 4000000) - 2000000;
    y1 = $urandom_range(0, 4000000) - 2000000;
    sx = $urandom_range(0, 400) - 200;
    sy = $urandom_range(0, 400) - 200;
    sag = $urandom_range(0, 2000) - 1000;
    p.x1 = 24'(x1); p.y1 = 24'(y1); p.z1 = 24'(z1);
    p.x2 = 24'(x1 + sx * s1 / 1000);
    p.y2 = 24'(y1 + sy * s1 / 1000 + sag);
    p.z2 = 24'(z1 + s1);
    p.x3 = 24'(x1 + sx * s2 / 1000);
    p.y3 = 24'(y1 + sy * s2 / 1000);
    p.z3 = 24'(z1 + s2);
    if ($urandom_range(0, 9) == 0) p.y2 = 24'(y1 + sy * s1 / 1000);
    return p;
  endfunction

  task automatic write_reg(tpts_pkg::cfg_idx_e idx, logic [23:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tpts_pkg::CFG_ORIGIN_Z) plane_z = value;
    else field_b = value[17:0];
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_seeds.size() != 0 || start_i) begin
      @(posedge clk_i);
    end
    repeat (LatencyCycles + 10) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    burst_mode = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) pending_words = {pending_words, random_points()};
      else pending_words = {pending_words, track_points()};
    end
    while (pending_words.size() != 0) @(posedge clk_i);
    burst_mode = 1'b0;
  endtask

  initial begin
    points_t p;
    plane_z = 24'sd0;
    field_b = 18'd37356;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = tpts_pkg::CFG_ORIGIN_Z;
    cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    p = '{default: '0};
    pending_words = {pending_words, p};
    p = '{24'sd100, 24'sd5, 24'sd0, 24'sd300, 24'sd9, 24'sd0, 24'sd1, 24'sd1, 24'sd500};
    pending_words = {pending_words, p};
    p = '{24'sd100, 24'sd5, 24'sd10, 24'sd300, 24'sd9, 24'sd20, 24'sd100, 24'sd5, 24'sd10};
    pending_words = {pending_words, p};
    p = '{24'sd0, 24'sd0, 24'sd0, 24'sd1000, 24'sd2000, 24'sd1000, 24'sd2000, 24'sd4000,
          24'sd2000};
    pending_words = {pending_words, p};
    p = '{24'sd0, 24'sd0, 24'sd0, -24'sd5000, 24'sd0, 24'sd1000, 24'sd0, 24'sd50, 24'sd2000};
    pending_words = {pending_words, p};
    p = '{24'sd7, 24'sd7, 24'sd0, 24'sd7, 24'sd7, -24'sd1000, 24'sd0, 24'sd9, -24'sd2000};
    pending_words = {pending_words, p};
    p = '{24'sd8388607, 24'sd8388607, 24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388606,
          24'sd8388607, -24'sd8388608, -24'sd8388608};
    pending_words = {pending_words, p};
    p = '{-24'sd8388608, -24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607,
          24'sd8388607, -24'sd8388608, 24'sd8388607, -24'sd8388607};
    pending_words = {pending_words, p};
    p = '{24'sd0, 24'sd0, 24'sd8000000, 24'sd8000000, 24'sd8000000, 24'sd8000001, 24'sd0,
          24'sd0, 24'sd8000002};
    pending_words = {pending_words, p};
    p = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd0, 24'sd0, 24'sd8388607};
    pending_words = {pending_words, p};
    p = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, -24'sd1, 24'sd8388607, 24'sd0, 24'sd0, 24'sd1};
    pending_words = {pending_words, p};
    p = '{24'sd0, 24'sd0, 24'sd0, -24'sd3, -24'sd4, -24'sd5, 24'sd0, 24'sd9, -24'sd10};
    pending_words = {pending_words, p};
    random_phase(320);
    drain();

    write_reg(tpts_pkg::CFG_ORIGIN_Z, 24'h800000);
    write_reg(tpts_pkg::CFG_FIELD_STRENGTH, 24'd1);
    random_phase(340);
    drain();
    write_reg(tpts_pkg::CFG_ORIGIN_Z, 24'h7FFFFF);
    write_reg(tpts_pkg::CFG_FIELD_STRENGTH, 24'h03FFFF);
    random_phase(340);
    drain();
    write_reg(tpts_pkg::CFG_ORIGIN_Z, 24'($urandom()));
    write_reg(tpts_pkg::CFG_FIELD_STRENGTH, 24'd0);
    random_phase(340);
    drain();
    write_reg(tpts_pkg::CFG_ORIGIN_Z, 24'($urandom()));
    write_reg(tpts_pkg::CFG_FIELD_STRENGTH, 24'($urandom_range(1, 262143)));
    random_phase(340);
    drain();

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  always @(negedge clk_i) begin
    points_t p;
    if (rst_ni) begin
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        p = pending_words.pop_front();
        {first_x_i, first_y_i, first_z_i} <= {p.x1, p.y1, p.z1};
        {second_x_i, second_y_i, second_z_i} <= {p.x2, p.y2, p.z2};
        {third_x_i, third_y_i, third_z_i} <= {p.x3, p.y3, p.z3};
        start_i <= 1'b1;
        gap_left <= burst_mode ? 0 : $urandom_range(0, 9);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    points_t p;
    seed_t e;
    bit active;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      active = 1'b0;
      if (start_i && !busy_o) begin
        p = '{first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i,
              third_x_i, third_y_i, third_z_i};
        expected_seeds = {expected_seeds, estimate_seed(p)};
        active = 1'b1;
      end
      if (done_o) begin
        active = 1'b1;
        if (expected_seeds.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_seeds.pop_front();
          if (loc_x_o !== e.loc_x) begin
            $error("loc_x expected %0d actual %0d", e.loc_x, loc_x_o); errors++;
          end
          if (loc_y_o !== e.loc_y) begin
            $error("loc_y expected %0d actual %0d", e.loc_y, loc_y_o); errors++;
          end
          if (azimuth_o !== e.azimuth) begin
            $error("azimuth expected %0d actual %0d", e.azimuth, azimuth_o); errors++;
          end
          if (polar_angle_o !== e.polar) begin
            $error("polar_angle expected %0d actual %0d", e.polar, polar_angle_o); errors++;
          end
          if (charge_over_momentum_o !== e.qop) begin
            $error("charge_over_momentum expected %0d actual %0d", e.qop,
                   charge_over_momentum_o);
            errors++;
          end
          if (degenerate_o !== e.degen) begin
            $error("degenerate expected %0d actual %0d", e.degen, degenerate_o); errors++;
          end
        end
      end
      idle_cycles <= active ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
sv/tpts_pkg.sv
sv/tpts_cordic.sv
sv/three_point_track_seed_params.sv
sim/tb_three_point_track_seed_params.sv
